// ----- design/bclfu_pkg.sv -----
`timescale 1ns / 1ps
package bclfu_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int BLK_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = 16;
  localparam int DIV_W      = 22;
  localparam int BS_W       = 17;
  localparam int MR_W       = 7;
  localparam int CFG_W      = 22;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [MR_W-1:0]  TOTAL_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_RESIDENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILE_LENGTH  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_DIV1,
    ST_DIV2,
    ST_RANGE,
    ST_BLK,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_EVICT,
    ST_PLACE,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_EMIT,
    ST_ERR
  } state_t;

  typedef struct packed {
    logic cap_in;
    logic div_start;
    logic div_sel;
    logic latch_q1;
    logic latch_q2;
    logic blk_init;
    logic alloc_free;
    logic scan_init;
    logic scan_skip;
    logic rd_en;
    logic rd_sel_blk;
    logic scan_eval;
    logic evict_fin;
    logic place;
    logic cnt_wr;
    logic emit_load;
    logic emit_err;
  } cmd_t;

  typedef struct packed {
    logic req_bad;
    logic div_done;
    logic range_bad;
    logic resident;
    logic free_slot;
    logic idx_end;
    logic idx_res;
    logic stop_now;
    logic out_free;
    logic is_last;
  } sts_t;

endpackage

// ----- design/bclfu_div.sv -----
`timescale 1ns / 1ps
module bclfu_div
  import bclfu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [BS_W-1:0]  divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient,
  output logic [BS_W-1:0]  remainder
);

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic [BS_W-1:0]   acc_r, acc_nxt;
  logic [DIV_W-1:0]  q_r, q_nxt;
  logic [BS_W-1:0]   dsr_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r, done_r;
  logic [BS_W:0]     trial;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial   = {acc_r, q_r[DIV_W-1]};
    acc_nxt = trial[BS_W-1:0];
    q_nxt   = {q_r[DIV_W-2:0], 1'b0};
    if (trial >= {1'b0, dsr_r}) begin
      acc_nxt = BS_W'(trial - {1'b0, dsr_r});
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      q_r   <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = acc_r;

endmodule

// ----- design/bclfu_dp.sv -----
`timescale 1ns / 1ps
module bclfu_dp
  import bclfu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic [31:0]          in_seek,
  input  logic [31:0]          in_size,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [BLK_W-1:0]     out_block_index,
  output logic                 out_hit,
  output logic                 out_evicted,
  output logic [BLK_W-1:0]     out_evicted_block,
  output logic [15:0]          out_offset_in_block,
  output logic [16:0]          out_byte_count,
  output logic                 out_error,
  output logic                 out_last
);

  logic [MR_W-1:0]  max_res_r;
  logic [BS_W-1:0]  bsize_r;
  logic [DIV_W-1:0] flen_r;

  logic [31:0]      seek_r, size_r;
  logic [DIV_W-1:0] bstart_r, pos_r, remain_r, bend_r;
  logic [BLK_W-1:0] blk_r, lastb_r;
  logic             q2_big_r;

  logic [MAX_BLOCKS-1:0] flag_r, vld_r;
  logic [MR_W-1:0]       total_r;
  logic [CNT_W-1:0]      cnt_mem [MAX_BLOCKS];
  logic [CNT_W-1:0]      rd_data_r;

  logic [BLK_W:0]   idx_r;
  logic             started_r;
  logic [CNT_W-1:0] min_r;
  logic [BLK_W-1:0] vict_r;
  logic             hit_r, ev_r;
  logic [BLK_W-1:0] evb_r;

  logic             ov_r, oh_r, oe_r, oerr_r, olast_r;
  logic [BLK_W-1:0] oblk_r, oevb_r;
  logic [15:0]      ooff_r;
  logic [16:0]      ocnt_r;

  logic [BS_W-1:0]  bs;
  logic [MR_W-1:0]  cap;
  logic [32:0]      end_sum;
  logic [DIV_W-1:0] dividend;
  logic             div_done;
  logic [DIV_W-1:0] quo;
  logic [BS_W-1:0]  rem;
  logic [DIV_W:0]   bend_sum;
  logic [DIV_W-1:0] span, serve;
  logic [BLK_W-1:0] idx;
  logic [BLK_W-1:0] rd_addr;
  logic [CNT_W-1:0] scan_c, blk_c;

  assign bs       = (bsize_r == '0) ? BS_W'(1) : bsize_r;
  assign cap      = (max_res_r == '0) ? MR_W'(1) : max_res_r;
  assign end_sum  = {1'b0, seek_r} + {1'b0, size_r};
  assign dividend = cmd.div_sel ? DIV_W'(end_sum[DIV_W-1:0] - 1'b1) : seek_r[DIV_W-1:0];
  assign bend_sum = {1'b0, bstart_r} + {6'b0, bs};
  assign span     = bend_r - pos_r;
  assign serve    = (span > remain_r) ? remain_r : span;
  assign idx      = idx_r[BLK_W-1:0];
  assign rd_addr  = cmd.rd_sel_blk ? blk_r : idx;
  assign scan_c   = vld_r[idx] ? rd_data_r : '0;
  assign blk_c    = vld_r[blk_r] ? rd_data_r : '0;

  bclfu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (bs),
    .done     (div_done),
    .quotient (quo),
    .remainder(rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_res_r <= MR_W'(8);
      bsize_r   <= BS_W'(4096);
      flen_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_RESIDENT: max_res_r <= cfg_data[MR_W-1:0];
        REG_BLOCK_SIZE:   bsize_r   <= cfg_data[BS_W-1:0];
        REG_FILE_LENGTH:  flen_r    <= cfg_data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // request and per-block walk
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      seek_r <= in_seek;
      size_r <= in_size;
    end
    if (cmd.latch_q1) begin
      bstart_r <= seek_r[DIV_W-1:0] - {5'b0, rem};
      blk_r    <= quo[BLK_W-1:0];
      pos_r    <= seek_r[DIV_W-1:0];
      remain_r <= size_r[DIV_W-1:0];
    end
    if (cmd.latch_q2) begin
      lastb_r  <= quo[BLK_W-1:0];
      q2_big_r <= (quo >= DIV_W'(MAX_BLOCKS));
    end
    if (cmd.blk_init) begin
      bend_r <= (bend_sum > {1'b0, flen_r}) ? flen_r : bend_sum[DIV_W-1:0];
    end
    if (cmd.emit_load) begin
      pos_r    <= pos_r + serve;
      remain_r <= remain_r - serve;
      bstart_r <= bend_sum[DIV_W-1:0];
      blk_r    <= blk_r + 1'b1;
    end
  end

  // directory state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r  <= '0;
      vld_r   <= '0;
      total_r <= '0;
    end else begin
      if (cmd.alloc_free) total_r <= total_r + 1'b1;
      if (cmd.scan_eval) vld_r[idx] <= 1'b0;
      if (cmd.evict_fin) begin
        if (started_r) flag_r[vict_r] <= 1'b0;
        else if (total_r != TOTAL_MAX) total_r <= total_r + 1'b1;
      end
      if (cmd.place) begin
        flag_r[blk_r] <= 1'b1;
        vld_r[blk_r]  <= 1'b0;
      end
      if (cmd.cnt_wr) vld_r[blk_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_wr) cnt_mem[blk_r] <= (blk_c == CNT_MAX) ? blk_c : blk_c + 1'b1;
    if (cmd.rd_en) rd_data_r <= cnt_mem[rd_addr];
  end

  // victim scan
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      idx_r     <= '0;
      started_r <= 1'b0;
    end
    if (cmd.scan_skip) idx_r <= idx_r + 1'b1;
    if (cmd.scan_eval) begin
      idx_r     <= idx_r + 1'b1;
      started_r <= 1'b1;
      if (!started_r || scan_c < min_r) begin
        min_r  <= scan_c;
        vict_r <= idx;
      end
    end
    if (cmd.blk_init) begin
      hit_r <= flag_r[blk_r];
      ev_r  <= 1'b0;
      evb_r <= '0;
    end
    if (cmd.evict_fin && started_r) begin
      ev_r  <= 1'b1;
      evb_r <= vict_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit_load || cmd.emit_err) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      oblk_r  <= blk_r;
      oh_r    <= hit_r;
      oe_r    <= ev_r;
      oevb_r  <= evb_r;
      ooff_r  <= 16'(pos_r - bstart_r);
      ocnt_r  <= 17'(serve);
      oerr_r  <= 1'b0;
      olast_r <= (blk_r == lastb_r);
    end else if (cmd.emit_err) begin
      oblk_r  <= '0;
      oh_r    <= 1'b0;
      oe_r    <= 1'b0;
      oevb_r  <= '0;
      ooff_r  <= '0;
      ocnt_r  <= '0;
      oerr_r  <= 1'b1;
      olast_r <= 1'b1;
    end
  end

  always_comb begin
    sts.req_bad   = (size_r == '0) || (end_sum > {11'b0, flen_r});
    sts.div_done  = div_done;
    sts.range_bad = q2_big_r;
    sts.resident  = flag_r[blk_r];
    sts.free_slot = (total_r < cap);
    sts.idx_end   = idx_r[BLK_W];
    sts.idx_res   = flag_r[idx];
    sts.stop_now  = (!started_r || scan_c < min_r) && (scan_c == '0);
    sts.out_free  = !ov_r || !out_stall;
    sts.is_last   = (blk_r == lastb_r);
  end

  assign out_valid           = ov_r;
  assign out_block_index     = oblk_r;
  assign out_hit             = oh_r;
  assign out_evicted         = oe_r;
  assign out_evicted_block   = oevb_r;
  assign out_offset_in_block = ooff_r;
  assign out_byte_count      = ocnt_r;
  assign out_error           = oerr_r;
  assign out_last            = olast_r;

endmodule

// ----- design/bclfu_ctrl.sv -----
`timescale 1ns / 1ps
module bclfu_ctrl
  import bclfu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_CHK;
      ST_CHK:     state_nxt = sts.req_bad ? ST_ERR : ST_DIV1;
      ST_DIV1:    if (sts.div_done) state_nxt = ST_DIV2;
      ST_DIV2:    if (sts.div_done) state_nxt = ST_RANGE;
      ST_RANGE:   state_nxt = sts.range_bad ? ST_ERR : ST_BLK;
      ST_BLK: begin
        if (sts.resident)       state_nxt = ST_CNT_RD;
        else if (sts.free_slot) state_nxt = ST_PLACE;
        else                    state_nxt = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        if (sts.idx_end)      state_nxt = ST_EVICT;
        else if (sts.idx_res) state_nxt = ST_SCAN_EV;
      end
      ST_SCAN_EV: state_nxt = sts.stop_now ? ST_EVICT : ST_SCAN_RD;
      ST_EVICT:   state_nxt = ST_PLACE;
      ST_PLACE:   state_nxt = ST_CNT_RD;
      ST_CNT_RD:  state_nxt = ST_CNT_WR;
      ST_CNT_WR:  state_nxt = ST_EMIT;
      ST_EMIT:    if (sts.out_free) state_nxt = sts.is_last ? ST_IDLE : ST_BLK;
      ST_ERR:     if (sts.out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.cap_in = in_valid;
      end
      ST_CHK:  cmd.div_start = !sts.req_bad;
      ST_DIV1: begin
        cmd.latch_q1  = sts.div_done;
        cmd.div_start = sts.div_done;
        cmd.div_sel   = 1'b1;
      end
      ST_DIV2: cmd.latch_q2 = sts.div_done;
      ST_RANGE: ;
      ST_BLK: begin
        cmd.blk_init   = 1'b1;
        cmd.alloc_free = !sts.resident && sts.free_slot;
        cmd.scan_init  = !sts.resident && !sts.free_slot;
      end
      ST_SCAN_RD: begin
        cmd.rd_en     = !sts.idx_end && sts.idx_res;
        cmd.scan_skip = !sts.idx_end && !sts.idx_res;
      end
      ST_SCAN_EV: cmd.scan_eval = 1'b1;
      ST_EVICT:   cmd.evict_fin = 1'b1;
      ST_PLACE:   cmd.place = 1'b1;
      ST_CNT_RD: begin
        cmd.rd_en      = 1'b1;
        cmd.rd_sel_blk = 1'b1;
      end
      ST_CNT_WR:  cmd.cnt_wr = 1'b1;
      ST_EMIT:    cmd.emit_load = sts.out_free;
      ST_ERR:     cmd.emit_err = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ----- design/block_cache_lfu_directory.sv -----
`timescale 1ns / 1ps
// channel   direction  handshake           payload
// in        input      in_valid/in_stall   in_seek, in_size
// out       output     out_valid/out_stall block, hit, eviction, offset, count, error, last
// cfg       input      cfg_we              cfg_index, cfg_data
//
// one request at a time: it is checked and then split by two divider passes,
// then each block takes the hit, free-slot or eviction path, an eviction adding the scan
// (each resident block read and compared, each empty index skipped, up to a zero count or the end)
// reset is synchronous and active low; the directory comes up empty
// a result waits in the output register while the next block is worked on;
// a stalled output holds the walk only when the next result is ready
module block_cache_lfu_directory
  import bclfu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          in_seek,
  input  logic [31:0]          in_size,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BLK_W-1:0]     out_block_index,
  output logic                 out_hit,
  output logic                 out_evicted,
  output logic [BLK_W-1:0]     out_evicted_block,
  output logic [15:0]          out_offset_in_block,
  output logic [16:0]          out_byte_count,
  output logic                 out_error,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: request check, division, per-block directory update
  bclfu_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  // registers, directory, count memory and output stage
  bclfu_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_seek            (in_seek),
    .in_size            (in_size),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_block_index    (out_block_index),
    .out_hit            (out_hit),
    .out_evicted        (out_evicted),
    .out_evicted_block  (out_evicted_block),
    .out_offset_in_block(out_offset_in_block),
    .out_byte_count     (out_byte_count),
    .out_error          (out_error),
    .out_last           (out_last)
  );

  // an error item always closes its request
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last)
    else $error("error item without last");

  // a hit never displaces a block
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evicted)
    else $error("hit with eviction");

  // victim index is zero when nothing was evicted
  a_evb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted |-> out_evicted_block == '0)
    else $error("stray evicted block index");

  // an accepted request keeps the input closed on the next cycle
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

endmodule
